// ----- design/rhpq_pkg.sv -----
// ----------------------------------------------------------------------------
// rhpq_pkg: shared constants and modular helpers
// Operation codes, the hash prime and small add/subtract helpers modulo the
// prime, used by the sequencer and the shared modular multiplier.
// ----------------------------------------------------------------------------
package rhpq_pkg;

    localparam int HASH_W = 30;
    localparam logic [HASH_W-1:0] HASH_PRIME = 30'd1000000007;
    localparam logic [HASH_W-1:0] BASE_RESET = 30'd31;
    localparam int MUL_STEPS = HASH_W;
    localparam int MUL_CNT_W = 5;
    localparam int CODE_W = 6;

    localparam int APB_AW = 3;
    localparam logic REG_HASH_BASE = 1'b0;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_QUERY  = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    // x < 2*prime in, x mod prime out
    function automatic logic [HASH_W-1:0] mod_fold(input logic [HASH_W:0] x);
        logic [HASH_W:0] d;
        begin
            d = x - {1'b0, HASH_PRIME};
            mod_fold = (x >= {1'b0, HASH_PRIME}) ? d[HASH_W-1:0] : x[HASH_W-1:0];
        end
    endfunction

    function automatic logic [HASH_W-1:0] mod_add(input logic [HASH_W-1:0] a,
                                                  input logic [HASH_W-1:0] b);
        begin
            mod_add = mod_fold({1'b0, a} + {1'b0, b});
        end
    endfunction

    function automatic logic [HASH_W-1:0] mod_sub(input logic [HASH_W-1:0] a,
                                                  input logic [HASH_W-1:0] b);
        logic [HASH_W:0] s;
        begin
            if (a >= b) begin
                s = {1'b0, a} - {1'b0, b};
            end else begin
                s = {1'b0, a} + {1'b0, HASH_PRIME} - {1'b0, b};
            end
            mod_sub = s[HASH_W-1:0];
        end
    endfunction

endpackage

// ----- design/rhpq_modmul.sv -----
// ----------------------------------------------------------------------------
// rhpq_modmul: iterative modular multiplier
// Computes a*b mod the hash prime by MSB-first shift-and-add, one bit of b
// per cycle. Both operands must already be below the prime.
// ----------------------------------------------------------------------------
module rhpq_modmul
    import rhpq_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [HASH_W-1:0] op_a,
    input  logic [HASH_W-1:0] op_b,
    output logic              done,
    output logic [HASH_W-1:0] product
);

    logic [HASH_W-1:0]    a_reg;
    logic [HASH_W-1:0]    b_reg;
    logic [HASH_W-1:0]    acc_reg;
    logic [HASH_W-1:0]    acc_next;
    logic [MUL_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [HASH_W-1:0]    dbl;

    always_comb begin
        dbl      = mod_fold({acc_reg, 1'b0});
        acc_next = b_reg[HASH_W-1] ? mod_add(dbl, a_reg) : dbl;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= MUL_CNT_W'(MUL_STEPS - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - MUL_CNT_W'(1);
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= op_a;
            b_reg   <= op_b;
            acc_reg <= '0;
        end else if (busy_reg) begin
            acc_reg <= acc_next;
            b_reg   <= {b_reg[HASH_W-2:0], 1'b0};
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// ----- design/rolling_hash_palindrome_query.sv -----
// ----------------------------------------------------------------------------
// rolling_hash_palindrome_query: substring palindrome test by rolling hash
// Builds a string letter by letter and answers range palindrome queries.
// ----------------------------------------------------------------------------
// Each append stores base power, forward prefix hash and power-weighted
// prefix sum modulo 1000000007 in three on-chip memories; a query reads up
// to two entries of each and compares the range hash against its reverse.
// All modular products go through one shared shift-and-add multiplier; each
// product holds the sequencer while it is launched, worked through in 30
// multiply steps and handed back, which limits the throughput. An append
// needs three products, the first letter of a string is written without
// any, and an append to a full string is dropped; a valid query needs two
// products, or one when the range starts at 0, and its result may wait in
// the done state for the output register to be read; a bad-range query
// goes straight to the done state, and a clear or an unused operation
// returns straight to idle. The input is not ready while an item is in
// work. A result waits in an output register, so the next item is accepted
// while it is still unread. The memories need no clearing after reset;
// hash_base is written through the APB port at address 0.
// ----------------------------------------------------------------------------
module rolling_hash_palindrome_query
    import rhpq_pkg::*;
#(
    parameter int MAX_LEN = 4096
) (
    input  logic              aclk,
    input  logic              aresetn,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // input items
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_operation,
    input  logic [4:0]        s_letter,
    input  logic [11:0]       s_left_index,
    input  logic [11:0]       s_right_index,
    // results
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_is_palindrome,
    output logic              m_bad_range
);

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int CW = (LW > 12) ? LW : 12;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_AREAD  = 11'b000_0000_0010,
        S_AMUL1  = 11'b000_0000_0100,
        S_AMUL2  = 11'b000_0000_1000,
        S_AMUL3  = 11'b000_0001_0000,
        S_WRITE  = 11'b000_0010_0000,
        S_QREAD  = 11'b000_0100_0000,
        S_QLATCH = 11'b000_1000_0000,
        S_QMUL1  = 11'b001_0000_0000,
        S_QMUL2  = 11'b010_0000_0000,
        S_DONE   = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [HASH_W-1:0] base_reg;
    logic [HASH_W-1:0] base_mod;
    logic [LW-1:0]     len_reg;

    logic [CODE_W-1:0] code_reg;
    logic [11:0]       left_reg;
    logic [11:0]       right_reg;

    logic [HASH_W-1:0] h_acc_reg;
    logic [HASH_W-1:0] g_acc_reg;
    logic [HASH_W-1:0] p_acc_reg;
    logic              res_pal_reg;
    logic              res_bad_reg;
    logic              m_valid_reg;
    logic              m_pal_reg;
    logic              m_bad_reg;
    logic              mul_pend_reg;

    logic [HASH_W-1:0] h_mem [MAX_LEN];
    logic [HASH_W-1:0] g_mem [MAX_LEN];
    logic [HASH_W-1:0] p_mem [MAX_LEN];
    logic [HASH_W-1:0] h_q_reg;
    logic [HASH_W-1:0] g_q_reg;
    logic [HASH_W-1:0] p_q_reg;
    logic [AW-1:0]     h_addr;
    logic [AW-1:0]     g_addr;
    logic [AW-1:0]     p_addr;
    logic              rd_en;

    logic              in_mul;
    logic              mul_start;
    logic              mul_done;
    logic [HASH_W-1:0] mul_a;
    logic [HASH_W-1:0] mul_b;
    logic [HASH_W-1:0] mul_prod;

    logic              s_fire;
    logic              cfg_wr;
    logic              bad_q;
    logic              left_zero;
    logic [HASH_W-1:0] code_ext;
    logic [HASH_W:0]   base_diff;

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_HASH_BASE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= BASE_RESET;
        end else if (cfg_wr) begin
            base_reg <= pwdata[HASH_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_HASH_BASE) begin
            prdata = {{(32 - HASH_W){1'b0}}, base_reg};
        end
    end

    // base below 2^30 < 2*prime, so one fold reduces it
    assign base_diff = {1'b0, base_reg} - {1'b0, HASH_PRIME};
    assign base_mod  = (base_reg >= HASH_PRIME) ? base_diff[HASH_W-1:0] : base_reg;

    // ------------------------------------------------------------------
    // handshake and decode
    // ------------------------------------------------------------------
    assign s_ready   = (state_reg == S_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign bad_q     = (s_left_index > s_right_index)
                    || (CW'(s_right_index) >= CW'(len_reg));
    assign left_zero = (left_reg == '0);
    assign code_ext  = HASH_W'(code_reg);

    // ------------------------------------------------------------------
    // shared multiplier
    // ------------------------------------------------------------------
    assign in_mul    = (state_reg == S_AMUL1) || (state_reg == S_AMUL2)
                    || (state_reg == S_AMUL3) || (state_reg == S_QMUL1)
                    || (state_reg == S_QMUL2);
    assign mul_start = in_mul && !mul_pend_reg;

    always_comb begin
        mul_a = h_acc_reg;
        mul_b = p_acc_reg;
        case (state_reg)
            S_AMUL1: begin
                mul_a = p_q_reg;
                mul_b = base_mod;
            end
            S_AMUL2: begin
                mul_a = h_q_reg;
                mul_b = base_mod;
            end
            S_AMUL3: begin
                mul_a = code_ext;
                mul_b = p_acc_reg;
            end
            S_QMUL1: begin
                mul_a = h_q_reg;
                mul_b = p_q_reg;
            end
            default: begin
                mul_a = h_acc_reg;
                mul_b = p_acc_reg;
            end
        endcase
    end

    rhpq_modmul u_modmul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .product (mul_prod)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_pend_reg <= 1'b0;
        end else if (mul_start) begin
            mul_pend_reg <= 1'b1;
        end else if (mul_done) begin
            mul_pend_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // prefix tables
    // ------------------------------------------------------------------
    always_comb begin
        h_addr = AW'(right_reg);
        g_addr = AW'(right_reg);
        p_addr = AW'(left_reg);
        rd_en  = 1'b0;
        case (state_reg)
            S_AREAD: begin
                h_addr = AW'(len_reg - LW'(1));
                g_addr = AW'(len_reg - LW'(1));
                p_addr = AW'(len_reg - LW'(1));
                rd_en  = 1'b1;
            end
            S_QREAD: begin
                rd_en = 1'b1;
            end
            S_QLATCH: begin
                h_addr = AW'(left_reg - 12'd1);
                g_addr = AW'(left_reg - 12'd1);
                p_addr = AW'(right_reg - left_reg + 12'd1);
                rd_en  = !left_zero;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_WRITE) begin
            h_mem[len_reg[AW-1:0]] <= h_acc_reg;
            g_mem[len_reg[AW-1:0]] <= g_acc_reg;
            p_mem[len_reg[AW-1:0]] <= p_acc_reg;
        end
        if (rd_en) begin
            h_q_reg <= h_mem[h_addr];
            g_q_reg <= g_mem[g_addr];
            p_q_reg <= p_mem[p_addr];
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    case (s_operation)
                        OP_APPEND: begin
                            if (len_reg == LW'(MAX_LEN)) begin
                                state_next = S_IDLE;
                            end else if (len_reg == '0) begin
                                state_next = S_WRITE;
                            end else begin
                                state_next = S_AREAD;
                            end
                        end
                        OP_QUERY: begin
                            state_next = bad_q ? S_DONE : S_QREAD;
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_AREAD:  state_next = S_AMUL1;
            S_AMUL1:  if (mul_done) state_next = S_AMUL2;
            S_AMUL2:  if (mul_done) state_next = S_AMUL3;
            S_AMUL3:  if (mul_done) state_next = S_WRITE;
            S_WRITE:  state_next = S_IDLE;
            S_QREAD:  state_next = S_QLATCH;
            S_QLATCH: state_next = left_zero ? S_QMUL2 : S_QMUL1;
            S_QMUL1:  if (mul_done) state_next = S_QMUL2;
            S_QMUL2:  if (mul_done) state_next = S_DONE;
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            len_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (s_fire && (s_operation == OP_CLEAR)) begin
                len_reg <= '0;
            end else if (state_reg == S_WRITE) begin
                len_reg <= len_reg + LW'(1);
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            code_reg    <= CODE_W'(s_letter) + CODE_W'(1);
            left_reg    <= s_left_index;
            right_reg   <= s_right_index;
            res_pal_reg <= 1'b0;
            res_bad_reg <= 1'b1;
            // first letter: seed the row directly
            h_acc_reg   <= HASH_W'(s_letter) + HASH_W'(1);
            g_acc_reg   <= HASH_W'(s_letter) + HASH_W'(1);
            p_acc_reg   <= HASH_W'(1);
        end else begin
            case (state_reg)
                S_AMUL1: begin
                    if (mul_done) p_acc_reg <= mul_prod;
                end
                S_AMUL2: begin
                    if (mul_done) h_acc_reg <= mod_add(mul_prod, code_ext);
                end
                S_AMUL3: begin
                    if (mul_done) g_acc_reg <= mod_add(g_q_reg, mul_prod);
                end
                S_QLATCH: begin
                    h_acc_reg <= h_q_reg;
                    g_acc_reg <= g_q_reg;
                    p_acc_reg <= p_q_reg;
                end
                S_QMUL1: begin
                    if (mul_done) begin
                        h_acc_reg <= mod_sub(h_acc_reg, mul_prod);
                        g_acc_reg <= mod_sub(g_acc_reg, g_q_reg);
                    end
                end
                S_QMUL2: begin
                    if (mul_done) begin
                        res_pal_reg <= (mul_prod == g_acc_reg);
                        res_bad_reg <= 1'b0;
                    end
                end
                default: begin
                    code_reg <= code_reg;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((state_reg == S_DONE) && (!m_valid_reg || m_ready)) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == S_DONE) && (!m_valid_reg || m_ready)) begin
            m_pal_reg <= res_pal_reg;
            m_bad_reg <= res_bad_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_is_palindrome = m_pal_reg;
    assign m_bad_range     = m_bad_reg;

endmodule
